// ----- hdl/szpc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the spatial zero pad / crop block.
// No dependencies; every other file takes names from here by scope.
package szpc_pkg;

  localparam int PAD_W   = 12;  // signed pad register width
  localparam int DIM_W   = 13;  // unsigned dimension register width
  localparam int WORD_W  = 32;  // pixel word width
  localparam int RUN_W   = 23;  // run length width
  localparam int POS_W   = 16;  // signed width for position compares
  localparam int DATA_W  = 32;  // configuration data width
  localparam int ADDR_W  = 5;   // configuration byte address width
  localparam int IDX_W   = 3;   // register index width
  localparam int N_REG   = 6;   // number of configuration registers
  localparam int Q_DEPTH = 4;   // front-to-back queue depth
  localparam int Q_PTR_W = 2;   // queue pointer width
  localparam int N_SLOT  = 5;   // results one pixel can cause

  localparam int DEF_MAX_DIM = 4096;
  localparam int DEF_MAX_PAD = 1024;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_PAD_LEFT   = 3'd0;
  localparam logic [IDX_W-1:0] REG_PAD_RIGHT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_PAD_TOP    = 3'd2;
  localparam logic [IDX_W-1:0] REG_PAD_BOTTOM = 3'd3;
  localparam logic [IDX_W-1:0] REG_IN_WIDTH   = 3'd4;
  localparam logic [IDX_W-1:0] REG_IN_HEIGHT  = 3'd5;

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  // One-hot result slots, in emission order
  localparam logic [N_SLOT-1:0] SLOT_TOP    = 5'b00001;
  localparam logic [N_SLOT-1:0] SLOT_LEFT   = 5'b00010;
  localparam logic [N_SLOT-1:0] SLOT_DATA   = 5'b00100;
  localparam logic [N_SLOT-1:0] SLOT_RIGHT  = 5'b01000;
  localparam logic [N_SLOT-1:0] SLOT_BOTTOM = 5'b10000;

  typedef struct packed {
    logic signed [PAD_W-1:0] pad_left;
    logic signed [PAD_W-1:0] pad_right;
    logic signed [PAD_W-1:0] pad_top;
    logic signed [PAD_W-1:0] pad_bottom;
    logic [DIM_W-1:0]        in_width;
    logic [DIM_W-1:0]        in_height;
    logic [RUN_W-1:0]        run_top;
    logic [RUN_W-1:0]        run_bottom;
  } cfg_t;

  // One classified pixel: which results it causes, and its word
  typedef struct packed {
    logic [N_SLOT-1:0] slots;  // bit order as the SLOT_ codes
    logic              pend;   // last kept pixel, no bottom run follows
    logic [WORD_W-1:0] word;
  } ent_t;

endpackage

// ----- hdl/szpc_ifs.sv -----
`timescale 1ns / 1ps
// Stream interfaces of the pad / crop block: pixel input and result output.
// Depends on szpc_pkg for field widths.
interface szpc_pix_if;
  logic                          valid;
  logic                          ready;
  logic [szpc_pkg::WORD_W-1:0]   pixel_word;

  modport source (output valid, output pixel_word, input ready);
  modport sink   (input valid, input pixel_word, output ready);
endinterface

interface szpc_res_if;
  logic                          valid;
  logic                          ready;
  logic                          item_kind;
  logic [szpc_pkg::WORD_W-1:0]   word_value;
  logic [szpc_pkg::RUN_W-1:0]    run_length;
  logic                          plane_end;
  logic                          last_of_input;

  modport source (output valid, output item_kind, output word_value, output run_length,
                  output plane_end, output last_of_input, input ready);
  modport sink   (input valid, input item_kind, input word_value, input run_length,
                  input plane_end, input last_of_input, output ready);
endinterface

// ----- hdl/szpc_cfg.sv -----
`timescale 1ns / 1ps
// Configuration registers with APB-style access, saturation and run products.
// Depends on szpc_pkg.
module szpc_cfg #(
  parameter int MAX_DIM = szpc_pkg::DEF_MAX_DIM,
  parameter int MAX_PAD = szpc_pkg::DEF_MAX_PAD
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [szpc_pkg::ADDR_W-1:0]   paddr,
  input  logic [szpc_pkg::DATA_W-1:0]   pwdata,
  output logic [szpc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output szpc_pkg::cfg_t                cfg,
  output logic                          clear
);

  localparam int PAD_TOPV = 2 ** (szpc_pkg::PAD_W - 1);
  localparam int PAD_HI   = (MAX_PAD < PAD_TOPV - 1) ? MAX_PAD : PAD_TOPV - 1;
  localparam int PAD_LO   = (MAX_PAD < PAD_TOPV) ? -MAX_PAD : -PAD_TOPV;
  localparam int DIM_TOPV = 2 ** szpc_pkg::DIM_W - 1;
  localparam int DIM_HI   = (MAX_DIM < DIM_TOPV) ? MAX_DIM : DIM_TOPV;
  localparam int PROD_W   = szpc_pkg::PAD_W + szpc_pkg::POS_W;

  logic signed [szpc_pkg::PAD_W-1:0] pad_left, pad_right, pad_top, pad_bottom;
  logic [szpc_pkg::DIM_W-1:0]        in_width, in_height;
  logic [szpc_pkg::RUN_W-1:0]        run_top, run_bottom;
  logic [szpc_pkg::IDX_W-1:0]        idx;
  logic                              wr;
  logic signed [szpc_pkg::POS_W-1:0] ow;
  logic signed [PROD_W-1:0]          top_prod, bottom_prod;

  function automatic logic signed [szpc_pkg::PAD_W-1:0] sat_pad(
    input logic [szpc_pkg::PAD_W-1:0] raw);
    logic signed [szpc_pkg::PAD_W-1:0] s;
    int                                v;
    s = $signed(raw);
    v = int'(s);
    if (v > PAD_HI) begin
      s = szpc_pkg::PAD_W'(PAD_HI);
    end else if (v < PAD_LO) begin
      s = szpc_pkg::PAD_W'(PAD_LO);
    end
    return s;
  endfunction

  function automatic logic [szpc_pkg::DIM_W-1:0] clamp_dim(
    input logic [szpc_pkg::DIM_W-1:0] raw);
    logic [szpc_pkg::DIM_W-1:0] u;
    u = raw;
    if (u == '0) begin
      u = szpc_pkg::DIM_W'(1);
    end else if (int'(u) > DIM_HI) begin
      u = szpc_pkg::DIM_W'(DIM_HI);
    end
    return u;
  endfunction

  assign pready = 1'b1;
  assign idx    = paddr[szpc_pkg::ADDR_W-1:2];
  assign wr     = psel & penable & pwrite & pready;
  assign clear  = wr && (idx < szpc_pkg::IDX_W'(szpc_pkg::N_REG));

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_left   <= '0;
      pad_right  <= '0;
      pad_top    <= '0;
      pad_bottom <= '0;
      in_width   <= szpc_pkg::DIM_W'(1);
      in_height  <= szpc_pkg::DIM_W'(1);
    end else if (wr) begin
      case (idx)
        szpc_pkg::REG_PAD_LEFT:   pad_left   <= sat_pad(pwdata[szpc_pkg::PAD_W-1:0]);
        szpc_pkg::REG_PAD_RIGHT:  pad_right  <= sat_pad(pwdata[szpc_pkg::PAD_W-1:0]);
        szpc_pkg::REG_PAD_TOP:    pad_top    <= sat_pad(pwdata[szpc_pkg::PAD_W-1:0]);
        szpc_pkg::REG_PAD_BOTTOM: pad_bottom <= sat_pad(pwdata[szpc_pkg::PAD_W-1:0]);
        szpc_pkg::REG_IN_WIDTH:   in_width   <= clamp_dim(pwdata[szpc_pkg::DIM_W-1:0]);
        szpc_pkg::REG_IN_HEIGHT:  in_height  <= clamp_dim(pwdata[szpc_pkg::DIM_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      szpc_pkg::REG_PAD_LEFT:   prdata = szpc_pkg::DATA_W'($unsigned(pad_left));
      szpc_pkg::REG_PAD_RIGHT:  prdata = szpc_pkg::DATA_W'($unsigned(pad_right));
      szpc_pkg::REG_PAD_TOP:    prdata = szpc_pkg::DATA_W'($unsigned(pad_top));
      szpc_pkg::REG_PAD_BOTTOM: prdata = szpc_pkg::DATA_W'($unsigned(pad_bottom));
      szpc_pkg::REG_IN_WIDTH:   prdata = szpc_pkg::DATA_W'(in_width);
      szpc_pkg::REG_IN_HEIGHT:  prdata = szpc_pkg::DATA_W'(in_height);
      default:                  prdata = '0;
    endcase
  end

  // Output width and the top / bottom run products; only used when positive
  assign ow = $signed({{(szpc_pkg::POS_W - szpc_pkg::DIM_W){1'b0}}, in_width})
              + szpc_pkg::POS_W'(pad_left) + szpc_pkg::POS_W'(pad_right);
  assign top_prod    = pad_top * ow;
  assign bottom_prod = pad_bottom * ow;

  always_ff @(posedge clk) begin
    run_top    <= top_prod[szpc_pkg::RUN_W-1:0];
    run_bottom <= bottom_prod[szpc_pkg::RUN_W-1:0];
  end

  always_comb begin
    cfg.pad_left   = pad_left;
    cfg.pad_right  = pad_right;
    cfg.pad_top    = pad_top;
    cfg.pad_bottom = pad_bottom;
    cfg.in_width   = in_width;
    cfg.in_height  = in_height;
    cfg.run_top    = run_top;
    cfg.run_bottom = run_bottom;
  end

endmodule

// ----- hdl/szpc_front.sv -----
`timescale 1ns / 1ps
// Front end: accept pixels, track raster position, classify into queue entries.
// Depends on szpc_pkg and szpc_pix_if.
module szpc_front #(
  parameter int CNT_W = 12
) (
  input  logic              clk,
  input  logic              rst,
  szpc_pix_if.sink          pix,
  input  szpc_pkg::cfg_t    cfg,
  input  logic              clear,
  input  logic              q_full,
  output logic              push,
  output szpc_pkg::ent_t    push_ent
);

  localparam int PW = szpc_pkg::POS_W;

  logic [CNT_W-1:0]    col, row;
  logic                accept;
  logic signed [PW-1:0] pl, pr, pt, pb, iw, ih, cx, ry;
  logic signed [PW-1:0] x1, x2, y1, y2;
  logic                any, kept, first_in, last_col, last_row;
  logic                top_on, left_on, right_on, bottom_on, at_x2;

  assign pix.ready = !q_full;
  assign accept    = pix.valid & pix.ready;

  assign pl = PW'($signed(cfg.pad_left));
  assign pr = PW'($signed(cfg.pad_right));
  assign pt = PW'($signed(cfg.pad_top));
  assign pb = PW'($signed(cfg.pad_bottom));
  assign iw = $signed({{(PW - szpc_pkg::DIM_W){1'b0}}, cfg.in_width});
  assign ih = $signed({{(PW - szpc_pkg::DIM_W){1'b0}}, cfg.in_height});
  assign cx = $signed({{(PW - CNT_W){1'b0}}, col});
  assign ry = $signed({{(PW - CNT_W){1'b0}}, row});

  // Kept window [x1, x2) x [y1, y2)
  assign x1 = pl[PW-1] ? -pl : '0;
  assign x2 = pr[PW-1] ? iw + pr : iw;
  assign y1 = pt[PW-1] ? -pt : '0;
  assign y2 = pb[PW-1] ? ih + pb : ih;

  assign any      = (x2 > x1) && (y2 > y1);
  assign kept     = any && (cx >= x1) && (cx < x2) && (ry >= y1) && (ry < y2);
  assign first_in = (col == '0) && (row == '0);
  assign last_col = (cx == iw - PW'(1));
  assign last_row = (ry == ih - PW'(1));
  assign at_x2    = (cx == x2 - PW'(1));

  assign top_on    = any && first_in && (pt > 0);
  assign left_on   = kept && (cx == x1) && (pl > 0);
  assign right_on  = kept && at_x2 && (pr > 0);
  assign bottom_on = any && last_col && last_row && (pb > 0);

  always_comb begin
    push_ent.slots = '0;
    if (top_on)    push_ent.slots = push_ent.slots | szpc_pkg::SLOT_TOP;
    if (left_on)   push_ent.slots = push_ent.slots | szpc_pkg::SLOT_LEFT;
    if (kept)      push_ent.slots = push_ent.slots | szpc_pkg::SLOT_DATA;
    if (right_on)  push_ent.slots = push_ent.slots | szpc_pkg::SLOT_RIGHT;
    if (bottom_on) push_ent.slots = push_ent.slots | szpc_pkg::SLOT_BOTTOM;
    push_ent.pend = kept && at_x2 && (ry == y2 - PW'(1)) && !(pb > 0);
    push_ent.word = pix.pixel_word;
  end

  // Drop pixels that cause nothing; the counters still advance
  assign push = accept && (push_ent.slots != '0);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + CNT_W'(1);
      end else begin
        col <= col + CNT_W'(1);
      end
    end
  end

endmodule

// ----- hdl/szpc_queue.sv -----
`timescale 1ns / 1ps
// Short FIFO that decouples the classifying front from the expanding back.
// Depends on szpc_pkg.
module szpc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  szpc_pkg::ent_t    push_ent,
  output logic              full,
  input  logic              pop,
  output szpc_pkg::ent_t    head,
  output logic              empty
);

  szpc_pkg::ent_t               slots_q [szpc_pkg::Q_DEPTH];
  logic [szpc_pkg::Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [szpc_pkg::Q_PTR_W:0]   count;

  assign full  = (count == (szpc_pkg::Q_PTR_W + 1)'(szpc_pkg::Q_DEPTH));
  assign empty = (count == '0);
  assign head  = slots_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots_q[wr_ptr] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + szpc_pkg::Q_PTR_W'(1);
      if (pop && !empty) rd_ptr <= rd_ptr + szpc_pkg::Q_PTR_W'(1);
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + (szpc_pkg::Q_PTR_W + 1)'(1);
        2'b01:   count <= count - (szpc_pkg::Q_PTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hdl/szpc_back.sv -----
`timescale 1ns / 1ps
// Back end: expand each queue entry into results, one per cycle unless res
// stalls, via a registered output stage. Depends on szpc_pkg and szpc_res_if.
module szpc_back (
  input  logic              clk,
  input  logic              rst,
  input  szpc_pkg::cfg_t    cfg,
  input  szpc_pkg::ent_t    head,
  input  logic              empty,
  output logic              pop,
  szpc_res_if.source        res
);

  localparam int NS = szpc_pkg::N_SLOT;

  logic [NS-1:0]               done;
  logic [NS-1:0]               rem, sel;
  logic                        last, advance;
  logic                        kind_n, pend_n;
  logic [szpc_pkg::WORD_W-1:0] word_n;
  logic [szpc_pkg::RUN_W-1:0]  len_n;

  assign rem     = head.slots & ~done;
  assign sel     = rem & (~rem + NS'(1));
  assign last    = (rem & ~sel) == '0;
  assign advance = !empty && (!res.valid || res.ready);
  assign pop     = advance && last;

  always_comb begin
    kind_n = szpc_pkg::KIND_RUN;
    word_n = '0;
    pend_n = 1'b0;
    case (sel)
      szpc_pkg::SLOT_TOP:    len_n = cfg.run_top;
      szpc_pkg::SLOT_LEFT:   len_n = szpc_pkg::RUN_W'($unsigned(cfg.pad_left));
      szpc_pkg::SLOT_DATA: begin
        kind_n = szpc_pkg::KIND_DATA;
        word_n = head.word;
        len_n  = szpc_pkg::RUN_W'(1);
        pend_n = head.pend && ((head.slots & szpc_pkg::SLOT_RIGHT) == '0);
      end
      szpc_pkg::SLOT_RIGHT: begin
        len_n  = szpc_pkg::RUN_W'($unsigned(cfg.pad_right));
        pend_n = head.pend;
      end
      szpc_pkg::SLOT_BOTTOM: begin
        len_n  = cfg.run_bottom;
        pend_n = 1'b1;
      end
      default:               len_n = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
      done      <= '0;
    end else begin
      if (advance) begin
        res.valid <= 1'b1;
        done      <= last ? '0 : (done | sel);
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.item_kind     <= kind_n;
      res.word_value    <= word_n;
      res.run_length    <= len_n;
      res.plane_end     <= pend_n;
      res.last_of_input <= last;
    end
  end

  // No partial progress without an entry to work on
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    empty |-> (done == '0))
    else $error("result mask set with empty queue");

  // A waiting entry always has at least one result left
  a_work_left: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (rem != '0))
    else $error("queue entry with nothing left to emit");

  // Finishing an entry restarts the mask for the next one
  a_pop_clear: assert property (@(posedge clk) disable iff (rst)
    pop |=> (done == '0))
    else $error("result mask not cleared after pop");

endmodule

// ----- hdl/spatial_zero_pad_crop.sv -----
`timescale 1ns / 1ps
// Top level of the spatial zero pad / crop block.
// Depends on szpc_pkg, szpc_ifs, szpc_cfg, szpc_front, szpc_queue, szpc_back.
//
// Usage:
//   pix carries one plane's pixels in raster order, one 32-bit word per
//   transaction (valid/ready). res carries results: data pixels and
//   zero-run descriptors (top, left, data, right, bottom per pixel), with
//   plane_end on the last result of the output plane and last_of_input on
//   the last result caused by each pixel.
//   The APB-style port holds six registers at byte addresses 4*i; write them
//   only while the block is idle. Any write to one of them restarts the plane.
// Timing:
//   With the queue empty, a pixel's first result passes through the queue
//   and then the output register before it turns valid on res.
//   Pixels are taken one per cycle while the queue is not full; the back end
//   emits one result per cycle while res is not stalled.
//   Pixels that cause no result are dropped and take no queue entry.
// Reset (rst, synchronous): registers take their defaults, the position
//   counters and the four-entry queue clear, res.valid drops.
// Stall: a stalled result holds in the output register, the queue fills,
//   and pix.ready falls once the queue is full.
module spatial_zero_pad_crop #(
  parameter int MAX_DIM = szpc_pkg::DEF_MAX_DIM,
  parameter int MAX_PAD = szpc_pkg::DEF_MAX_PAD
) (
  input  logic                          clk,
  input  logic                          rst,
  szpc_pix_if.sink                      pix,
  szpc_res_if.source                    res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [szpc_pkg::ADDR_W-1:0]   paddr,
  input  logic [szpc_pkg::DATA_W-1:0]   pwdata,
  output logic [szpc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  // Counter width follows the largest dimension: MAX_DIM, capped at what the 13-bit field can hold
  localparam int DIM_TOPV = 2 ** szpc_pkg::DIM_W - 1;
  localparam int DIM_HI   = (MAX_DIM < DIM_TOPV) ? MAX_DIM : DIM_TOPV;
  localparam int CNT_W    = $clog2(DIM_HI);

  szpc_pkg::cfg_t cfg;
  szpc_pkg::ent_t push_ent, head;
  logic           clear, push, q_full, q_empty, pop;

  // Register file and derived run products
  szpc_cfg #(
    .MAX_DIM (MAX_DIM),
    .MAX_PAD (MAX_PAD)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .clear   (clear)
  );

  // Front: position tracking and classification
  szpc_front #(
    .CNT_W (CNT_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .pix      (pix),
    .cfg      (cfg),
    .clear    (clear),
    .q_full   (q_full),
    .push     (push),
    .push_ent (push_ent)
  );

  // Decoupling queue
  szpc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_ent (push_ent),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  // Back: result expansion and output register
  szpc_back u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .head  (head),
    .empty (q_empty),
    .pop   (pop),
    .res   (res)
  );

endmodule
